// ===== design/iplpr_pkg.sv =====
// Package for the IPv4 longest-prefix route table.
// Holds widths, operation and status codes, the queued item type and the mask helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iplpr_pkg;
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 32;
	localparam int PFX_W       = 6;
	localparam int ENTRY_W     = ADDR_W + PFX_W + ADDR_W;
	localparam int IN_DATA_W   = 72;
	localparam int OUT_DATA_W  = 48;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [PFX_W-1:0]  pfx;
		logic [ADDR_W-1:0] gw;
	} item_t;

	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] p);
		logic [ADDR_W-1:0] m;
		m = ~({ADDR_W{1'b1}} >> p);
		return m;
	endfunction
endpackage
`default_nettype wire

// ===== design/iplpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module iplpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/iplpr_front.sv =====
// Front end: accepts words, decodes the operation, clamps the prefix, queues up to two items.
// Depends on iplpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iplpr_front import iplpr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic [1:0]           s_axis_tuser,
	output logic                      q_valid,
	output item_t                     q_item,
	input  wire logic                 q_pop
);
	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	item_t      in_item;
	logic [PFX_W-1:0] raw_pfx;

	assign raw_pfx       = s_axis_tdata[37:32];
	assign in_item.op    = op_t'(s_axis_tuser);
	assign in_item.addr  = s_axis_tdata[31:0];
	assign in_item.pfx   = (raw_pfx > PFX_W'(ADDR_W)) ? PFX_W'(ADDR_W) : raw_pfx;
	assign in_item.gw    = s_axis_tdata[69:38];

	assign s_axis_tready = (fill_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (fill_q != 2'd0);
	assign q_item        = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end
endmodule
`default_nettype wire

// ===== design/iplpr_back.sv =====
// Back end: sequencer over the sorted route RAM; scan, shift, write and result register.
// Depends on iplpr_pkg and iplpr_ram.
`timescale 1ns / 1ps
`default_nettype none
module iplpr_back import iplpr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire item_t                 q_item,
	output logic                       q_pop,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [OUT_DATA_W-1:0] m_axis_tdata
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_SHRD = 6'b000100,
		S_SHWR = 6'b001000,
		S_WNEW = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

	state_t            state_q;
	item_t             op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  pos_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_hop_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_hop_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_valid_q;

	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [IDX_W-1:0]   raddr;
	logic [ENTRY_W-1:0] rdata;
	logic [ADDR_W-1:0]  e_addr;
	logic [PFX_W-1:0]   e_pfx;
	logic [ADDR_W-1:0]  e_gw;
	logic               last;
	logic               ins_hit;
	logic               rem_hit;
	logic               lk_hit;
	logic [CNT_W-1:0]   cnt_m1;

	iplpr_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign e_addr  = rdata[31:0];
	assign e_pfx   = rdata[37:32];
	assign e_gw    = rdata[69:38];
	assign cnt_m1  = cnt_q - CNT_W'(1);
	assign last    = ({1'b0, idx_q} == cnt_m1);
	assign ins_hit = (op_q.pfx > e_pfx) || ((op_q.pfx == e_pfx) && (op_q.addr < e_addr));
	assign rem_hit = (e_addr == op_q.addr) && (e_pfx == op_q.pfx) && (e_gw == op_q.gw);
	assign lk_hit  = ((op_q.addr & prefix_mask(e_pfx)) == e_addr);
	assign q_pop   = (state_q == S_IDLE);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_cnt_q, out_hop_q, out_status_q};

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata;
		raddr = idx_q + IDX_W'(1);
		unique case (state_q)
			S_IDLE: raddr = '0;
			S_SHRD: raddr = idx_q;
			S_SHWR: begin
				we    = 1'b1;
				waddr = (op_q.op == OP_INSERT) ? idx_q + IDX_W'(1) : idx_q - IDX_W'(1);
			end
			S_WNEW: begin
				we    = 1'b1;
				waddr = pos_q;
				wdata = {op_q.gw, op_q.pfx, op_q.addr};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q      <= q_item;
				idx_q     <= '0;
				pos_q     <= '0;
				res_hop_q <= '0;
			end
			S_SCAN: begin
				if (op_q.op == OP_INSERT && ins_hit) begin
					pos_q <= idx_q;
					idx_q <= cnt_m1[IDX_W-1:0];
				end else if (op_q.op == OP_INSERT && last) begin
					pos_q <= cnt_q[IDX_W-1:0];
				end else if (op_q.op == OP_LOOKUP && lk_hit) begin
					res_hop_q <= e_gw;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			S_SHWR: begin
				if (op_q.op == OP_INSERT) begin
					idx_q <= idx_q - IDX_W'(1);
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			default: ;
		endcase
		if (state_q == S_RESP && (!out_valid_q || m_axis_tready)) begin
			out_status_q <= res_status_q;
			out_hop_q    <= res_hop_q;
			out_cnt_q    <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			res_status_q <= ST_DONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						res_status_q <= ST_DONE;
						unique case (q_item.op)
							OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_RESP;
							end
							OP_INSERT: begin
								if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
									res_status_q <= ST_FULL;
									state_q      <= S_RESP;
								end else if (cnt_q == '0) begin
									state_q <= S_WNEW;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_MISS;
									state_q      <= S_RESP;
								end else begin
									state_q <= S_SCAN;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					unique case (op_q.op)
						OP_INSERT: begin
							if (ins_hit) begin
								state_q <= S_SHRD;
							end else if (last) begin
								state_q <= S_WNEW;
							end
						end
						OP_REMOVE: begin
							if (rem_hit) begin
								if (last) begin
									cnt_q   <= cnt_m1;
									state_q <= S_RESP;
								end else begin
									state_q <= S_SHRD;
								end
							end else if (last) begin
								res_status_q <= ST_MISS;
								state_q      <= S_RESP;
							end
						end
						default: begin
							if (lk_hit) begin
								state_q <= S_RESP;
							end else if (last) begin
								res_status_q <= ST_MISS;
								state_q      <= S_RESP;
							end
						end
					endcase
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					if (op_q.op == OP_INSERT) begin
						state_q <= (idx_q == pos_q) ? S_WNEW : S_SHRD;
					end else if (last) begin
						cnt_q   <= cnt_m1;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SHRD;
					end
				end
				S_WNEW: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/ipv4_longest_prefix_route_table_top.sv =====
// Throughput: one operation at a time; the sequencer walks the route RAM one entry per
// cycle on a scan; a shift reads each entry, then writes it through the single write port.
// A two-word input queue and the result register let both sides stall independently.
// Reset: asynchronous, clears the entry count, queue and result valid; RAM is not cleared.
// Depends on iplpr_pkg, iplpr_front, iplpr_back.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_longest_prefix_route_table_top import iplpr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // dest_address, prefix_len, gateway_in
	input  wire logic [1:0]            s_axis_tuser,  // mode
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [OUT_DATA_W-1:0] m_axis_tdata   // status, next_hop, entry_count
);
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	iplpr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	iplpr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);
endmodule
`default_nettype wire

// ===== design/iplpr_chk.sv =====
// Port checker for the route table top level, attached by bind.
// Depends on iplpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iplpr_chk import iplpr_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[42:34] <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above depth");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL |-> m_axis_tdata[42:34] == CNT_W'(TABLE_DEPTH))
		else $error("full status with room left");
	a_hop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != ST_DONE |-> m_axis_tdata[33:2] == '0)
		else $error("next hop on a failed operation");
endmodule

bind ipv4_longest_prefix_route_table_top iplpr_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== tb/ipv4_longest_prefix_route_table_top_tb.sv =====
// Testbench for ipv4_longest_prefix_route_table_top: a route table predictor checks every result word.
// Covers directed corner cases, a table fill to capacity and random route traffic under stalls.
// Depends on iplpr_pkg and the route table RTL.
`timescale 1ns / 1ps
module ipv4_longest_prefix_route_table_top_tb;
	import iplpr_pkg::*;

	localparam int RUN_LIMIT = 4000000;
	localparam int LONG_HOLD = 600;

	typedef struct {
		status_t          st;
		logic [31:0]      hop;
		logic [CNT_W-1:0] cnt;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = 2'd0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	logic [31:0] rt_addr [TABLE_DEPTH];
	logic [5:0]  rt_pfx [TABLE_DEPTH];
	logic [31:0] rt_gw [TABLE_DEPTH];
	int rt_count = 0;

	reply_t pending_replies[$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;
	bit hold_req = 1'b0;

	ipv4_longest_prefix_route_table_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] route_mask(input logic [5:0] p);
		if (p == 0)
			return 32'h0;
		return ~(32'hFFFF_FFFF >> p);
	endfunction

	function automatic reply_t route_table_apply(input op_t op, input logic [31:0] addr,
		input logic [5:0] pfx_raw, input logic [31:0] gw);
		reply_t r;
		logic [5:0] pfx;
		int i;
		int j;
		pfx = (pfx_raw > 6'd32) ? 6'd32 : pfx_raw;
		r.st = ST_DONE;
		r.hop = 32'h0;
		case (op)
			OP_INSERT: begin
				if (rt_count >= TABLE_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					for (i = 0; i < rt_count; i++)
						if (pfx > rt_pfx[i] || (pfx == rt_pfx[i] && addr < rt_addr[i]))
							break;
					for (j = rt_count; j > i; j--) begin
						rt_addr[j] = rt_addr[j-1];
						rt_pfx[j] = rt_pfx[j-1];
						rt_gw[j] = rt_gw[j-1];
					end
					rt_addr[i] = addr;
					rt_pfx[i] = pfx;
					rt_gw[i] = gw;
					rt_count++;
				end
			end
			OP_REMOVE: begin
				r.st = ST_MISS;
				for (i = 0; i < rt_count; i++)
					if (rt_addr[i] == addr && rt_pfx[i] == pfx && rt_gw[i] == gw) begin
						for (j = i; j + 1 < rt_count; j++) begin
							rt_addr[j] = rt_addr[j+1];
							rt_pfx[j] = rt_pfx[j+1];
							rt_gw[j] = rt_gw[j+1];
						end
						rt_count--;
						r.st = ST_DONE;
						break;
					end
			end
			OP_LOOKUP: begin
				r.st = ST_MISS;
				for (i = 0; i < rt_count; i++)
					if ((addr & route_mask(rt_pfx[i])) == rt_addr[i]) begin
						r.st = ST_DONE;
						r.hop = rt_gw[i];
						break;
					end
			end
			default: rt_count = 0;
		endcase
		r.cnt = rt_count[CNT_W-1:0];
		return r;
	endfunction

	task automatic send_word(input op_t op, input logic [31:0] addr, input logic [5:0] pfx,
		input logic [31:0] gw);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, gw, pfx, addr};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_replies.push_back(route_table_apply(op, addr, pfx, gw));
		burst_left--;
	endtask

	task automatic drain_replies();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		reply_t e;
		status_t got_st;
		if (m_axis_tvalid && m_axis_tready) begin
			got_st = status_t'(m_axis_tdata[1:0]);
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected word, actual %h", $time, m_axis_tdata);
				errors++;
			end else begin
				e = pending_replies.pop_front();
				if (got_st != e.st || m_axis_tdata[33:2] != e.hop
					|| m_axis_tdata[42:34] != e.cnt) begin
					$display("%0t: mismatch expected st=%0d hop=%h cnt=%0d actual st=%0d hop=%h cnt=%0d",
						$time, e.st, e.hop, e.cnt, got_st, m_axis_tdata[33:2],
						m_axis_tdata[42:34]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		int held;
		if (hold_req) begin
			hold_req = 1'b0;
			for (held = 0; held < LONG_HOLD; held++) begin
				m_axis_tready <= 1'b0;
				@(posedge clk);
			end
		end
		if ($urandom_range(0, 63) == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= (cycles % 5 < 2);
			default: m_axis_tready <= ($urandom_range(0, 1) != 0);
		endcase
	end

	function automatic logic [5:0] rand_prefix();
		if ($urandom_range(0, 19) == 0)
			return 6'($urandom_range(33, 63));
		if ($urandom_range(0, 9) == 0)
			return 6'($urandom_range(0, 1) ? 0 : 32);
		return 6'($urandom_range(8, 30));
	endfunction

	task automatic test_directed();
		send_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
		send_word(OP_REMOVE, 32'h0A00_0000, 6'd8, 32'h1);
		send_word(OP_INSERT, 32'h0, 6'd0, 32'hDEAD_BEEF);
		send_word(OP_INSERT, 32'h0A00_0000, 6'd8, 32'h0A00_0001);
		send_word(OP_INSERT, 32'h0A01_0000, 6'd16, 32'h0A01_0001);
		send_word(OP_INSERT, 32'h0A01_0000, 6'd16, 32'h0A01_0002);
		send_word(OP_INSERT, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
		send_word(OP_INSERT, 32'h0A02_0001, 6'd16, 32'h1234_5678);
		send_word(OP_LOOKUP, 32'h0A01_FFFF, 6'd0, 32'h0);
		send_word(OP_LOOKUP, 32'h0A02_0001, 6'd0, 32'h0);
		send_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
		send_word(OP_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0);
		send_word(OP_REMOVE, 32'h0A01_0000, 6'd16, 32'h0A01_0001);
		send_word(OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0);
		send_word(OP_REMOVE, 32'hFFFF_FFFF, 6'd40, 32'hFFFF_FFFF);
		send_word(OP_REMOVE, 32'h0A00_0000, 6'd8, 32'h0A00_0002);
		send_word(OP_REMOVE, 32'h0, 6'd0, 32'hDEAD_BEEF);
		send_word(OP_LOOKUP, 32'h1234_5678, 6'd0, 32'h0);
		send_word(OP_CLEAR, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
		send_word(OP_LOOKUP, 32'h0A00_0001, 6'd0, 32'h0);
		drain_replies();
	endtask

	task automatic test_fill_to_capacity();
		int k;
		logic [5:0] p;
		hold_req = 1'b1;
		for (k = 0; k < TABLE_DEPTH; k++) begin
			p = rand_prefix();
			send_word(OP_INSERT, $urandom & route_mask(p > 32 ? 6'd32 : p), p, $urandom);
		end
		send_word(OP_INSERT, $urandom, 6'd24, $urandom);
		send_word(OP_LOOKUP, $urandom, 6'd0, 32'h0);
		send_word(OP_REMOVE, rt_addr[0], rt_pfx[0], rt_gw[0]);
		send_word(OP_INSERT, 32'h0, 6'd0, 32'h5555_AAAA);
		send_word(OP_INSERT, 32'h0, 6'd0, 32'hAAAA_5555);
		send_word(OP_LOOKUP, $urandom, 6'd0, 32'h0);
		send_word(OP_CLEAR, 32'h0, 6'd0, 32'h0);
		drain_replies();
	endtask

	task automatic test_random_routes();
		int k;
		int sel;
		int idx;
		logic [5:0] p;
		for (k = 0; k < 1020; k++) begin
			sel = $urandom_range(0, 99);
			if (k % 300 == 150)
				hold_req = 1'b1;
			if (k % 400 == 399)
				drain_replies();
			if (rt_count > 40 && $urandom_range(0, 7) == 0) begin
				send_word(OP_CLEAR, $urandom, 6'($urandom), $urandom);
			end else if (sel < 35) begin
				p = rand_prefix();
				if ($urandom_range(0, 9) == 0)
					send_word(OP_INSERT, $urandom, p, $urandom);
				else if (rt_count > 0 && $urandom_range(0, 4) == 0) begin
					idx = $urandom_range(0, rt_count - 1);
					send_word(OP_INSERT, rt_addr[idx], rt_pfx[idx], $urandom);
				end else
					send_word(OP_INSERT, $urandom & route_mask(p > 32 ? 6'd32 : p), p,
						$urandom);
			end else if (sel < 55) begin
				if (rt_count > 0 && $urandom_range(0, 4) != 0) begin
					idx = $urandom_range(0, rt_count - 1);
					send_word(OP_REMOVE, rt_addr[idx], rt_pfx[idx], rt_gw[idx]);
				end else
					send_word(OP_REMOVE, $urandom, 6'($urandom), $urandom);
			end else if (sel < 97) begin
				if (rt_count > 0 && $urandom_range(0, 4) != 0) begin
					idx = $urandom_range(0, rt_count - 1);
					send_word(OP_LOOKUP, rt_addr[idx] | ($urandom & ~route_mask(rt_pfx[idx])),
						6'($urandom), $urandom);
				end else
					send_word(OP_LOOKUP, $urandom, 6'($urandom), $urandom);
			end else begin
				send_word(OP_CLEAR, $urandom, 6'($urandom), $urandom);
			end
		end
		drain_replies();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_to_capacity();
		test_random_routes();
		repeat (1000) @(posedge clk);
		if (errors == 0 && pending_replies.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
